// ===== hw/rtl/nirr_pkg.sv =====
// Shared types and constants for the NEC infrared remote decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nirr_pkg;

  // Event kinds carried by the command field
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_RISE = 2'd1,
    CMD_FALL = 2'd2,
    CMD_SCAN = 2'd3
  } cmd_t;

  // Classes of a measured high pulse
  typedef enum logic [2:0] {
    PULSE_NONE   = 3'd0,
    PULSE_LEAD   = 3'd1,
    PULSE_ZERO   = 3'd2,
    PULSE_ONE    = 3'd3,
    PULSE_REPEAT = 3'd4
  } pulse_t;

  // Pulse windows in microseconds, both bounds exclusive
  localparam logic [15:0] LEAD_LO = 16'd4200;
  localparam logic [15:0] LEAD_HI = 16'd4700;
  localparam logic [15:0] ZERO_LO = 16'd300;
  localparam logic [15:0] ZERO_HI = 16'd800;
  localparam logic [15:0] ONE_LO  = 16'd1400;
  localparam logic [15:0] ONE_HI  = 16'd1800;
  localparam logic [15:0] RPT_LO  = 16'd2200;
  localparam logic [15:0] RPT_HI  = 16'd2600;

  // Overflow count at which the next tick drops a held leader
  localparam logic [3:0] OVF_LIMIT = 4'd14;

  // One event handed from the input stage to the frame state
  typedef struct packed {
    logic   fire;
    cmd_t   cmd;
    pulse_t pulse;
  } event_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nirr_width_class.sv =====
// Pulse width classifier: sorts a high width into leader, bit or repeat.
// Depends on nirr_pkg for the window constants and pulse_t.
`timescale 1ns / 1ps
`default_nettype none

module nirr_width_class
  import nirr_pkg::*;
(
  input  wire logic [15:0] width,
  output pulse_t           pulse
);

  // Windows do not overlap, so at most one matches
  always_comb begin
    pulse = PULSE_NONE;
    if (width > LEAD_LO && width < LEAD_HI) begin
      pulse = PULSE_LEAD;
    end else if (width > ZERO_LO && width < ZERO_HI) begin
      pulse = PULSE_ZERO;
    end else if (width > ONE_LO && width < ONE_HI) begin
      pulse = PULSE_ONE;
    end else if (width > RPT_LO && width < RPT_HI) begin
      pulse = PULSE_REPEAT;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nirr_frame_state.sv =====
// Frame state of the decoder: leader, timeout, shift word and repeat tally,
// plus the address and complement check of a scan. Depends on nirr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nirr_frame_state
  import nirr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] own_addr,
  input  wire event_t     ev,
  output logic      [7:0] key,
  output logic      [7:0] tally
);

  logic        lead_seen, lead_seen_next;
  logic        key_ready, key_ready_next;
  logic        high_started, high_started_next;
  logic [3:0]  overflow_count, overflow_count_next;
  logic [31:0] shift_word, shift_word_next;
  logic [7:0]  repeat_tally, repeat_tally_next;

  logic [7:0] addr, addr_n, cmd_b, cmd_n;

  assign addr   = shift_word[31:24];
  assign addr_n = shift_word[23:16];
  assign cmd_b  = shift_word[15:8];
  assign cmd_n  = shift_word[7:0];

  // Key of the held frame, zero when any check fails or no key is ready
  always_comb begin
    key = 8'd0;
    if (key_ready && addr == ~addr_n && addr == own_addr && cmd_b == ~cmd_n) begin
      key = cmd_b;
    end
  end

  // Apply one event to the state
  always_comb begin
    lead_seen_next      = lead_seen;
    key_ready_next      = key_ready;
    high_started_next   = high_started;
    overflow_count_next = overflow_count;
    shift_word_next     = shift_word;
    repeat_tally_next   = repeat_tally;
    if (ev.fire) begin
      case (ev.cmd)
        CMD_TICK: begin
          if (lead_seen) begin
            high_started_next = 1'b0;
            if (overflow_count == 4'd0) begin
              key_ready_next = 1'b1;
            end
            if (overflow_count < OVF_LIMIT) begin
              overflow_count_next = overflow_count + 4'd1;
            end else begin
              lead_seen_next      = 1'b0;
              overflow_count_next = 4'd0;
            end
          end
        end
        CMD_RISE: begin
          high_started_next = 1'b1;
        end
        CMD_FALL: begin
          if (high_started) begin
            if (lead_seen) begin
              case (ev.pulse)
                PULSE_ZERO: shift_word_next = {shift_word[30:0], 1'b0};
                PULSE_ONE:  shift_word_next = {shift_word[30:0], 1'b1};
                PULSE_REPEAT: begin
                  repeat_tally_next   = repeat_tally + 8'd1;
                  overflow_count_next = 4'd0;
                end
                default: ;
              endcase
            end else if (ev.pulse == PULSE_LEAD) begin
              lead_seen_next    = 1'b1;
              repeat_tally_next = 8'd0;
            end
          end
          high_started_next = 1'b0;
        end
        CMD_SCAN: begin
          // Drop the key once read out unless a leader still holds it
          if (key_ready && (key == 8'd0 || !lead_seen)) begin
            key_ready_next    = 1'b0;
            repeat_tally_next = 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Tally as it stands after this event
  assign tally = repeat_tally_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_seen      <= 1'b0;
      key_ready      <= 1'b0;
      high_started   <= 1'b0;
      overflow_count <= 4'd0;
      shift_word     <= 32'd0;
      repeat_tally   <= 8'd0;
    end else begin
      lead_seen      <= lead_seen_next;
      key_ready      <= key_ready_next;
      high_started   <= high_started_next;
      overflow_count <= overflow_count_next;
      shift_word     <= shift_word_next;
      repeat_tally   <= repeat_tally_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nec_ir_remote_decoder_core.sv =====
// NEC infrared remote decoder, top level: input register, result register
// and handshakes. Depends on nirr_pkg, nirr_width_class, nirr_frame_state.
//
// Usage:
//   Input channel (in_valid / in_stall, fields command, high_width_us)
//   carries one event per request: overflow tick, rising edge, falling
//   edge with the measured high width, or scan request. Only a scan
//   request yields a result on the output channel (out_valid / out_stall,
//   fields key_code, repeat_tally_out); the other events only update state.
//   The user loads the expected remote address through cfg_we / cfg_wdata
//   only while the block is idle; the block itself does not enforce it.
// Path: a request is held in the input register; when a scan advances,
//   its result is loaded into the result register and out_valid rises.
// Throughput: one request per cycle while in_stall is low; one level of
//   compare and shift logic between the two registers updates frame state.
// Reset: rst (synchronous) clears both stages, the frame state and the
//   expected remote address.
// Stall: while a result waits under out_stall, a scan request in the input
//   register waits and in_stall rises; other events keep flowing, and a
//   result taken in the same cycle frees its slot at once.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_remote_decoder_core
  import nirr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] high_width_us,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  key_code,
  output logic      [7:0]  repeat_tally_out
);

  logic        stage_valid;
  cmd_t        stage_cmd;
  logic [15:0] stage_width;
  logic [7:0]  own_addr;
  logic        advance;
  logic        out_free;
  pulse_t      pulse;
  event_t      ev;
  logic [7:0]  key;
  logic [7:0]  tally;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= 8'd0;
    end else if (cfg_we) begin
      own_addr <= cfg_wdata;
    end
  end

  // A scan needs the result slot; other events always advance
  assign out_free = !out_valid || !out_stall;
  assign advance  = stage_valid && (stage_cmd != CMD_SCAN || out_free);
  assign in_stall = stage_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_cmd   <= cmd_t'(command);
      stage_width <= high_width_us;
    end
  end

  nirr_width_class u_class (
    .width (stage_width),
    .pulse (pulse)
  );

  assign ev = '{fire: advance, cmd: stage_cmd, pulse: pulse};

  nirr_frame_state u_state (
    .clk      (clk),
    .rst      (rst),
    .own_addr (own_addr),
    .ev       (ev),
    .key      (key),
    .tally    (tally)
  );

  // Result register: load on a scan, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_cmd == CMD_SCAN) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_cmd == CMD_SCAN) begin
      key_code         <= key;
      repeat_tally_out <= tally;
    end
  end

endmodule

`default_nettype wire
